/* hdl/rsofu_pkg.sv */
`timescale 1ns / 1ps
package rsofu_pkg;

    localparam int Q_BITS      = 16;   // quotient, Q1.15
    localparam int W_BITS      = 15;   // unsigned step weight
    localparam int W_ENTRIES   = 32;
    localparam int W_IDX_BITS  = 5;
    localparam int OUT_BITS    = 16;
    localparam int FRAC_SHIFT  = 16;
    localparam int UPC_BITS    = 3;
    localparam int PROG_STEPS  = 8;

    // round(65536000 / (k * 2929)), halves up, for k = 1 .. 32
    localparam logic [W_BITS-1:0] STEP_WEIGHT [W_ENTRIES] = '{
        15'd22375, 15'd11187, 15'd7458,  15'd5594,  15'd4475,  15'd3729,  15'd3196,
        15'd2797,  15'd2486,  15'd2237,  15'd2034,  15'd1865,  15'd1721,  15'd1598,
        15'd1492,  15'd1398,  15'd1316,  15'd1243,  15'd1178,  15'd1119,  15'd1065,
        15'd1017,  15'd973,   15'd932,   15'd895,   15'd861,   15'd829,   15'd799,
        15'd772,   15'd746,   15'd722,   15'd699
    };

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_TAKE,
        COND_TERM_DONE,
        COND_EQUAL,
        COND_DIV_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef logic [UPC_BITS-1:0] upc_t;

    typedef struct packed {
        logic  take_in;
        logic  load_term;
        logic  div_step;
        logic  mul;
        logic  acc;
        logic  tap_inc;
        logic  emit;
        cond_t cond;
        upc_t  target;
    } ucode_t;

    typedef struct packed {
        logic take_ok;
        logic term_done;
        logic equal;
        logic div_more;
        logic out_busy;
    } status_t;

endpackage

/* hdl/relative_slope_onset_function_unit.sv */
`timescale 1ns / 1ps
// channel | ports                    | payload
// input   | s_tvalid/s_tready/s_tdata | s_tdata: sample; s_tuser: restart
// output  | m_tvalid/m_tready/m_tdata | m_tdata: onset_strength (signed Q1.15)
//
// Each history entry that differs from the new sample runs the restoring divider
// (one quotient bit a cycle) and a multiply; entries equal to it skip both.
// Reset clears the sequencer, fill count, term index and output valid, not history.
// s_tready is high only while the sequencer waits; a result held on m_tdata by a
// low m_tready stalls the program in its final step until it is taken.
module relative_slope_onset_function_unit #(
    parameter int HISTORY_STEPS = 10,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_tdata,   // [SAMPLE_BITS-1:0] sample
    input  logic                                   s_tuser,   // [0] restart
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [rsofu_pkg::OUT_BITS-1:0]         m_tdata    // [15:0] onset_strength
);

    localparam int S_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    rsofu_pkg::ucode_t  ctrl;
    rsofu_pkg::status_t stat;

    rsofu_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    rsofu_datapath #(
        .HISTORY_STEPS (HISTORY_STEPS),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .S_DATA_BITS   (S_DATA_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .stat     (stat),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* hdl/rsofu_sequencer.sv */
`timescale 1ns / 1ps
module rsofu_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  rsofu_pkg::status_t  stat,
    output rsofu_pkg::ucode_t   ctrl
);

    localparam rsofu_pkg::upc_t STEP_WAIT  = 3'd0;
    localparam rsofu_pkg::upc_t STEP_CHECK = 3'd1;
    localparam rsofu_pkg::upc_t STEP_LOAD  = 3'd2;
    localparam rsofu_pkg::upc_t STEP_DIV   = 3'd3;
    localparam rsofu_pkg::upc_t STEP_MUL   = 3'd4;
    localparam rsofu_pkg::upc_t STEP_ACC   = 3'd5;
    localparam rsofu_pkg::upc_t STEP_SKIP  = 3'd6;
    localparam rsofu_pkg::upc_t STEP_FIN   = 3'd7;

    // fields: take_in, load_term, div_step, mul, acc, tap_inc, emit, cond, target
    // a condition that holds jumps to target, otherwise the next step follows;
    // the last step falls through to step 0
    localparam rsofu_pkg::ucode_t PROGRAM [rsofu_pkg::PROG_STEPS] = '{
        '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, rsofu_pkg::COND_NO_TAKE,   STEP_WAIT},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, rsofu_pkg::COND_TERM_DONE, STEP_FIN},
        '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, rsofu_pkg::COND_EQUAL,     STEP_SKIP},
        '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, rsofu_pkg::COND_DIV_MORE,  STEP_DIV},
        '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, rsofu_pkg::COND_NEVER,     STEP_WAIT},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, rsofu_pkg::COND_ALWAYS,    STEP_CHECK},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, rsofu_pkg::COND_ALWAYS,    STEP_CHECK},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, rsofu_pkg::COND_OUT_BUSY,  STEP_FIN}
    };

    rsofu_pkg::upc_t upc_reg;
    rsofu_pkg::upc_t upc_next;
    logic            cond_hit;

    assign ctrl = PROGRAM[upc_reg];

    always_comb begin
        case (ctrl.cond)
            rsofu_pkg::COND_NEVER:     cond_hit = 1'b0;
            rsofu_pkg::COND_ALWAYS:    cond_hit = 1'b1;
            rsofu_pkg::COND_NO_TAKE:   cond_hit = ~stat.take_ok;
            rsofu_pkg::COND_TERM_DONE: cond_hit = stat.term_done;
            rsofu_pkg::COND_EQUAL:     cond_hit = stat.equal;
            rsofu_pkg::COND_DIV_MORE:  cond_hit = stat.div_more;
            rsofu_pkg::COND_OUT_BUSY:  cond_hit = stat.out_busy;
            default:                   cond_hit = 1'b0;
        endcase
        upc_next = cond_hit ? ctrl.target : rsofu_pkg::upc_t'(upc_reg + 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= STEP_WAIT;
        end else begin
            upc_reg <= upc_next;
        end
    end

    a_take_starts_terms: assert property (@(posedge aclk) disable iff (!aresetn)
        (upc_reg == STEP_WAIT && stat.take_ok) |=> (upc_reg == STEP_CHECK))
        else $error("accepted transaction did not start the term loop");

    a_div_exits_to_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.div_step && !stat.div_more) |=> (upc_reg == STEP_MUL))
        else $error("divider exit did not go to multiply");

    a_equal_skips: assert property (@(posedge aclk) disable iff (!aresetn)
        (upc_reg == STEP_LOAD && stat.equal) |=> (upc_reg == STEP_SKIP))
        else $error("equal samples were not skipped");

endmodule

/* hdl/rsofu_datapath.sv */
`timescale 1ns / 1ps
module rsofu_datapath #(
    parameter int HISTORY_STEPS = 10,
    parameter int SAMPLE_BITS   = 16,
    parameter int S_DATA_BITS   = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rsofu_pkg::ucode_t                 ctrl,
    output rsofu_pkg::status_t                stat,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [S_DATA_BITS-1:0]            s_tdata,
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rsofu_pkg::OUT_BITS-1:0]    m_tdata
);

    localparam int TW = $clog2(HISTORY_STEPS + 1);
    localparam int IW = (HISTORY_STEPS > 1) ? $clog2(HISTORY_STEPS) : 1;
    localparam int DW = SAMPLE_BITS + 1;
    localparam int RW = SAMPLE_BITS + 2;
    localparam int CW = $clog2(rsofu_pkg::Q_BITS);
    localparam int PW = rsofu_pkg::Q_BITS + rsofu_pkg::W_BITS;
    localparam int AW = PW + TW;
    localparam int QB = rsofu_pkg::Q_BITS;
    localparam int OB = rsofu_pkg::OUT_BITS;

    typedef logic [TW-1:0]                     tap_t;
    typedef logic [DW-1:0]                     den_t;
    typedef logic [RW-1:0]                     rem_t;
    typedef logic [CW-1:0]                     dcnt_t;
    typedef logic signed [AW-1:0]              acc_t;
    typedef logic [rsofu_pkg::W_IDX_BITS-1:0]  widx_t;

    localparam acc_t SAT_HI = acc_t'(32767);
    localparam acc_t SAT_LO = acc_t'(-32768);

    logic [SAMPLE_BITS-1:0] hist_reg [HISTORY_STEPS];

    logic [SAMPLE_BITS-1:0] x_reg, x_next;
    tap_t                   fill_reg, fill_next;
    tap_t                   tap_reg, tap_next;
    logic                   neg_reg, neg_next;
    den_t                   den_reg, den_next;
    rem_t                   rem_reg, rem_next;
    logic [QB-1:0]          quo_reg, quo_next;
    dcnt_t                  dcnt_reg, dcnt_next;
    logic signed [PW-1:0]   prod_reg, prod_next;
    acc_t                   acc_reg, acc_next;
    logic                   out_valid_reg, out_valid_next;
    logic [OB-1:0]          out_data_reg, out_data_next;

    logic [SAMPLE_BITS-1:0]          xk;
    logic                            take_ok;
    logic                            emit_go;
    rem_t                            trial;
    logic                            fits;
    logic signed [QB-1:0]            q_val;
    logic [rsofu_pkg::W_BITS-1:0]    weight;
    logic signed [PW:0]              prod_full;
    acc_t                            shifted;
    logic [OB-1:0]                   sat_val;

    assign xk      = hist_reg[tap_reg[IW-1:0]];
    assign take_ok = ctrl.take_in & s_tvalid;
    assign s_tready = ctrl.take_in;

    assign stat.take_ok   = take_ok;
    assign stat.term_done = (tap_reg >= fill_reg);
    assign stat.equal     = (x_reg == xk);
    assign stat.div_more  = (dcnt_reg != dcnt_t'(QB - 1));
    assign stat.out_busy  = out_valid_reg & ~m_tready;

    assign emit_go = ctrl.emit & ~stat.out_busy;

    // restoring division, one quotient bit per step; the first step only compares
    // because the dividend magnitude never exceeds the divisor
    assign trial = (dcnt_reg == '0) ? rem_reg : {rem_reg[RW-2:0], 1'b0};
    assign fits  = (trial >= rem_t'(den_reg));

    // a quotient of +1 saturates; -1 is representable
    always_comb begin
        if (neg_reg) begin
            q_val = $signed(~quo_reg + 1'b1);
        end else if (quo_reg[QB-1]) begin
            q_val = $signed({1'b0, {(QB-1){1'b1}}});
        end else begin
            q_val = $signed(quo_reg);
        end
    end

    assign weight    = rsofu_pkg::STEP_WEIGHT[widx_t'(tap_reg)];
    assign prod_full = q_val * $signed({1'b0, weight});

    assign shifted = acc_reg >>> rsofu_pkg::FRAC_SHIFT;

    always_comb begin
        if (shifted > SAT_HI) begin
            sat_val = {1'b0, {(OB-1){1'b1}}};
        end else if (shifted < SAT_LO) begin
            sat_val = {1'b1, {(OB-1){1'b0}}};
        end else begin
            sat_val = shifted[OB-1:0];
        end
    end

    always_comb begin
        x_next         = x_reg;
        fill_next      = fill_reg;
        tap_next       = tap_reg;
        neg_next       = neg_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dcnt_next      = dcnt_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (take_ok) begin
            x_next   = s_tdata[SAMPLE_BITS-1:0];
            tap_next = '0;
            acc_next = '0;
            if (s_tuser) begin
                fill_next = '0;
            end
        end

        if (ctrl.load_term) begin
            neg_next  = (x_reg < xk);
            rem_next  = (x_reg < xk) ? rem_t'(xk - x_reg) : rem_t'(x_reg - xk);
            den_next  = den_t'(x_reg) + den_t'(xk);
            quo_next  = '0;
            dcnt_next = '0;
        end

        if (ctrl.div_step) begin
            rem_next  = fits ? rem_t'(trial - rem_t'(den_reg)) : trial;
            quo_next  = {quo_reg[QB-2:0], fits};
            dcnt_next = dcnt_t'(dcnt_reg + 1'b1);
        end

        if (ctrl.mul) begin
            prod_next = prod_full[PW-1:0];
        end

        if (ctrl.acc) begin
            acc_next = acc_t'(acc_reg + acc_t'(prod_reg));
        end

        if (ctrl.tap_inc) begin
            tap_next = tap_t'(tap_reg + 1'b1);
        end

        if (emit_go) begin
            out_valid_next = 1'b1;
            out_data_next  = sat_val;
            if (fill_reg != tap_t'(HISTORY_STEPS)) begin
                fill_next = tap_t'(fill_reg + 1'b1);
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            tap_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            fill_reg      <= fill_next;
            tap_reg       <= tap_next;
            out_valid_reg <= out_valid_next;
        end
        x_reg        <= x_next;
        neg_reg      <= neg_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        dcnt_reg     <= dcnt_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    // newest sample enters at the front once its result is out
    always_ff @(posedge aclk) begin
        if (emit_go) begin
            hist_reg[0] <= x_reg;
            for (int i = 1; i < HISTORY_STEPS; i++) begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_tap_within_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        tap_reg <= fill_reg)
        else $error("term index ran past the stored history");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= tap_t'(HISTORY_STEPS))
        else $error("fill count above history depth");

    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.div_step |=> (rem_reg < rem_t'(den_reg)))
        else $error("divider remainder not below divisor");

endmodule
